// ===== rtl/core/nrbh_pkg.sv =====
// Shared types, widths and the helper function of the nearest ray-box hit block.
package nrbh_pkg;

    localparam int DEFAULT_COORD_BITS = 32;
    localparam int DEFAULT_OWNER_BITS = 8;

    // Coordinates after extension hold the 32-bit field at any coordinate width.
    localparam int EXT_W   = 33;
    localparam int DIFF_W  = EXT_W + 1;
    localparam int AIM_W   = 18;
    localparam int DIST_W  = 31;
    localparam int FRAC_W  = 16;
    // Signed slab distance: magnitude below 2^(DIFF_W-1+FRAC_W), plus sign.
    localparam int T_W     = DIFF_W + FRAC_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AIM_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AIM_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AIM_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 3'd6;

    typedef struct packed {
        logic               box_present;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic [7:0]         owner;
        logic               last_item;
        logic               terrain_hit;
        logic [30:0]        terrain_distance;
    } in_t;

    typedef struct packed {
        logic               victim_found;
        logic [7:0]         victim;
        logic               terrain_won;
        logic [30:0]        hit_distance;
        logic signed [31:0] impact_x;
        logic signed [31:0] impact_y;
        logic signed [31:0] impact_z;
    } out_t;

    // Control tag that travels with one axis through the impact pipeline.
    typedef struct packed {
        logic       valid;
        logic [1:0] axis;
    } imp_tag_t;

    // Interprets a 32-bit word at the given coordinate width. Widths above 32
    // see the word as a positive number, since its upper bits are zero.
    function automatic logic signed [EXT_W-1:0] coord_ext(logic [31:0] v, int bits);
        logic [EXT_W-1:0] r;
        r = {1'b0, v};
        for (int i = 0; i < EXT_W; i++) begin
            if (bits <= 32 && i >= bits) begin
                r[i] = v[bits-1];
            end
        end
        return $signed(r);
    endfunction

endpackage

// ===== rtl/core/nrbh_div.sv =====
// Iterative signed divider that forms (num * 2^16) / den, rounded toward zero.
module nrbh_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [nrbh_pkg::DIFF_W-1:0] num,
    input  logic signed [nrbh_pkg::AIM_W-1:0]  den,
    output logic                               done,
    output logic signed [nrbh_pkg::T_W-1:0]    quot
);
    import nrbh_pkg::*;

    localparam int RADIX_BITS = 4;
    localparam int MAG_W      = DIFF_W - 1;
    localparam int DVD_RAW    = MAG_W + FRAC_W;
    localparam int DVD_W      = ((DVD_RAW + RADIX_BITS - 1) / RADIX_BITS) * RADIX_BITS;
    localparam int STEPS      = DVD_W / RADIX_BITS;
    localparam int CNT_W      = $clog2(STEPS);
    localparam int REM_W      = AIM_W;

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] q_reg, q_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] dv_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic signed [T_W-1:0] quot_reg;

    logic [MAG_W-1:0] num_mag;
    logic [REM_W-1:0] den_mag;
    logic [DIFF_W-1:0] num_abs;
    logic [AIM_W-1:0]  den_abs;

    assign num_abs = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
    assign den_abs = den[AIM_W-1] ? AIM_W'(-den) : AIM_W'(den);
    assign num_mag = num_abs[MAG_W-1:0];
    assign den_mag = den_abs;

    // Four restoring steps per cycle on the narrow remainder.
    always_comb begin
        logic [REM_W:0] trial;
        logic           qbit;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        q_next   = q_reg;
        for (int i = 0; i < RADIX_BITS; i++) begin
            trial    = {rem_next, dvd_next[DVD_W-1]};
            dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
            qbit     = (trial >= {1'b0, dv_reg});
            if (qbit) begin
                trial = trial - {1'b0, dv_reg};
            end
            rem_next = trial[REM_W-1:0];
            q_next   = {q_next[DVD_W-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= {{(DVD_W-DVD_RAW){1'b0}}, num_mag, {FRAC_W{1'b0}}};
                rem_reg  <= '0;
                q_reg    <= '0;
                dv_reg   <= den_mag;
                neg_reg  <= num[DIFF_W-1] ^ den[AIM_W-1];
            end else if (busy_reg) begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quot_reg <= neg_reg ? -$signed(q_next[T_W-1:0])
                                        : $signed(q_next[T_W-1:0]);
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/core/nrbh_impact.sv =====
// Two-stage impact unit: origin plus aim times distance over 2^16, saturated.
module nrbh_impact #(
    parameter int COORD_BITS = nrbh_pkg::DEFAULT_COORD_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  nrbh_pkg::imp_tag_t                 tag_in,
    input  logic signed [nrbh_pkg::AIM_W-1:0]  aim,
    input  logic [nrbh_pkg::DIST_W-1:0]        distance,
    input  logic signed [nrbh_pkg::EXT_W-1:0]  origin,
    output nrbh_pkg::imp_tag_t                 tag_out,
    output logic signed [31:0]                 value
);
    import nrbh_pkg::*;

    localparam int PROD_W   = AIM_W + DIST_W + 1;
    localparam int SUM_W    = 48;
    localparam int SAT_BITS = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam logic signed [SUM_W-1:0] SAT_HI = (48'sh1 <<< (SAT_BITS - 1)) - 48'sh1;
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - 48'sh1;

    imp_tag_t                 tag1_reg, tag2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [EXT_W-1:0]  origin_reg;
    logic signed [31:0]       value_reg;

    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] quo;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sat;

    // Truncating division by 2^16: bias negative products before the shift.
    assign adj = prod_reg + (prod_reg[PROD_W-1] ? $signed(PROD_W'(16'hFFFF))
                                                : $signed(PROD_W'(0)));
    assign quo = adj >>> FRAC_W;
    assign sum = SUM_W'(origin_reg) + SUM_W'(quo);
    assign sat = (sum > SAT_HI) ? SAT_HI : ((sum < SAT_LO) ? SAT_LO : sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end else begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
        prod_reg   <= aim * $signed({1'b0, distance});
        origin_reg <= origin;
        value_reg  <= sat[31:0];
    end

    assign tag_out = tag2_reg;
    assign value   = value_reg;

endmodule

// ===== rtl/core/nearest_ray_box_hit_top.sv =====
// Top level of the nearest ray-box hit block: sequencer, shot state and ports.
// Flow: an item without a box goes straight to the update; a box with no parallel axis
// runs six slab divisions, one after another on the one shared divider, plus sequencing;
// a parallel axis needs no division, only a check of the origin against the slabs.
// Throughput: one transaction at a time; s_ready is high only while the sequencer idles.
// After a last item, resolution and the impact unit run before the result is offered.
// Reset (aresetn, synchronous, active low) restores the register defaults and clears
// the running best and the output valid.
module nearest_ray_box_hit_top #(
    parameter int COORD_BITS = nrbh_pkg::DEFAULT_COORD_BITS,
    parameter int OWNER_BITS = nrbh_pkg::DEFAULT_OWNER_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  nrbh_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output nrbh_pkg::out_t                    m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nrbh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nrbh_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import nrbh_pkg::*;

    localparam logic [7:0] OWN_MASK =
        (OWNER_BITS >= 8) ? 8'hFF : 8'((32'd1 << OWNER_BITS) - 32'd1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_AXIS    = 4'd1;
    localparam logic [3:0] ST_DIV0    = 4'd2;
    localparam logic [3:0] ST_DIV1    = 4'd3;
    localparam logic [3:0] ST_SLAB    = 4'd4;
    localparam logic [3:0] ST_UPDATE  = 4'd5;
    localparam logic [3:0] ST_RESOLVE = 4'd6;
    localparam logic [3:0] ST_IMP     = 4'd7;
    localparam logic [3:0] ST_EMIT    = 4'd8;

    // Configuration registers. The user must write them only while idle; the block does not enforce it.
    logic signed [EXT_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [AIM_W-1:0] aim_x_reg, aim_y_reg, aim_z_reg;
    logic [DIST_W-1:0]       max_dist_reg;

    // Shot state. While no box is stored the running best is the maximum distance.
    logic [DIST_W-1:0] best_dist_reg;
    logic [7:0]        best_owner_reg;
    logic              owner_valid_reg;

    // Per-transaction working registers.
    logic [3:0]        state_reg;
    in_t               item_reg;
    logic [1:0]        axis_reg;
    logic              hit_reg;
    logic signed [T_W-1:0] enter_reg, exit_reg, t0_reg;
    logic [2:0]        imp_cnt_reg;

    // Resolved result, filled in before the output register is loaded.
    out_t              res_reg;
    logic              m_valid_reg;
    out_t              m_data_reg;

    logic signed [EXT_W-1:0] cur_o, cur_lo, cur_hi;
    logic signed [AIM_W-1:0] cur_d;
    logic [DIST_W-1:0]       running_best;

    logic                    div_start;
    logic signed [DIFF_W-1:0] div_num;
    logic                    div_done;
    logic signed [T_W-1:0]   div_quot;

    logic signed [T_W-1:0]   t_lo, t_hi, enter_new, exit_new;

    imp_tag_t                imp_tag_in, imp_tag_out;
    logic signed [AIM_W-1:0] imp_aim;
    logic signed [EXT_W-1:0] imp_origin;
    logic signed [31:0]      imp_value;

    assign running_best = owner_valid_reg ? best_dist_reg : max_dist_reg;

    // Operands of the axis under test.
    always_comb begin
        case (axis_reg)
            2'd0: begin
                cur_o  = origin_x_reg;
                cur_d  = aim_x_reg;
                cur_lo = coord_ext(item_reg.box_min_x, COORD_BITS);
                cur_hi = coord_ext(item_reg.box_max_x, COORD_BITS);
            end
            2'd1: begin
                cur_o  = origin_y_reg;
                cur_d  = aim_y_reg;
                cur_lo = coord_ext(item_reg.box_min_y, COORD_BITS);
                cur_hi = coord_ext(item_reg.box_max_y, COORD_BITS);
            end
            2'd2: begin
                cur_o  = origin_z_reg;
                cur_d  = aim_z_reg;
                cur_lo = coord_ext(item_reg.box_min_z, COORD_BITS);
                cur_hi = coord_ext(item_reg.box_max_z, COORD_BITS);
            end
            default: begin
                cur_o  = origin_x_reg;
                cur_d  = aim_x_reg;
                cur_lo = coord_ext(item_reg.box_min_x, COORD_BITS);
                cur_hi = coord_ext(item_reg.box_max_x, COORD_BITS);
            end
        endcase
    end

    // The lower slab is divided first, the upper one as soon as it finishes.
    assign div_start = ((state_reg == ST_AXIS) && (cur_d != '0)) ||
                       ((state_reg == ST_DIV0) && div_done);
    assign div_num   = (state_reg == ST_AXIS) ? DIFF_W'(cur_lo) - DIFF_W'(cur_o)
                                              : DIFF_W'(cur_hi) - DIFF_W'(cur_o);

    nrbh_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (cur_d),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Order the two slab distances and narrow the running interval.
    assign t_lo      = (t0_reg > div_quot) ? div_quot : t0_reg;
    assign t_hi      = (t0_reg > div_quot) ? t0_reg : div_quot;
    assign enter_new = (t_lo > enter_reg) ? t_lo : enter_reg;
    assign exit_new  = (t_hi < exit_reg) ? t_hi : exit_reg;

    // The impact unit gets the three axes in consecutive cycles.
    always_comb begin
        imp_tag_in.valid = (state_reg == ST_IMP) && (imp_cnt_reg < 3'd3);
        imp_tag_in.axis  = imp_cnt_reg[1:0];
        case (imp_cnt_reg[1:0])
            2'd0: begin
                imp_aim    = aim_x_reg;
                imp_origin = origin_x_reg;
            end
            2'd1: begin
                imp_aim    = aim_y_reg;
                imp_origin = origin_y_reg;
            end
            default: begin
                imp_aim    = aim_z_reg;
                imp_origin = origin_z_reg;
            end
        endcase
    end

    nrbh_impact #(
        .COORD_BITS (COORD_BITS)
    ) u_impact (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tag_in   (imp_tag_in),
        .aim      (imp_aim),
        .distance (res_reg.hit_distance),
        .origin   (imp_origin),
        .tag_out  (imp_tag_out),
        .value    (imp_value)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            aim_x_reg    <= 18'sd65536;
            aim_y_reg    <= '0;
            aim_z_reg    <= '0;
            max_dist_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= coord_ext(cfg_data, COORD_BITS);
                REG_ORIGIN_Y: origin_y_reg <= coord_ext(cfg_data, COORD_BITS);
                REG_ORIGIN_Z: origin_z_reg <= coord_ext(cfg_data, COORD_BITS);
                REG_AIM_X:    aim_x_reg    <= $signed(cfg_data[AIM_W-1:0]);
                REG_AIM_Y:    aim_y_reg    <= $signed(cfg_data[AIM_W-1:0]);
                REG_AIM_Z:    aim_z_reg    <= $signed(cfg_data[AIM_W-1:0]);
                REG_MAX_DIST: max_dist_reg <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer. A box walks the three axes; a parallel axis needs no division,
    // only a check that the origin lies between the two slabs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            owner_valid_reg <= 1'b0;
            best_owner_reg  <= '0;
            best_dist_reg   <= '0;
            m_valid_reg     <= 1'b0;
            imp_cnt_reg     <= '0;
        end else begin
            // While a result waits in the emit state, that state owns the output valid.
            if (m_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            if (imp_tag_out.valid) begin
                case (imp_tag_out.axis)
                    2'd0:    res_reg.impact_x <= imp_value;
                    2'd1:    res_reg.impact_y <= imp_value;
                    default: res_reg.impact_z <= imp_value;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        axis_reg  <= 2'd0;
                        hit_reg   <= 1'b0;
                        enter_reg <= '0;
                        exit_reg  <= T_W'(max_dist_reg);
                        state_reg <= s_data.box_present ? ST_AXIS : ST_UPDATE;
                    end
                end
                ST_AXIS: begin
                    if (cur_d != '0) begin
                        state_reg <= ST_DIV0;
                    end else if (cur_o < cur_lo || cur_o > cur_hi) begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_UPDATE;
                    end else if (axis_reg == 2'd2) begin
                        hit_reg   <= 1'b1;
                        state_reg <= ST_UPDATE;
                    end else begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
                ST_DIV0: begin
                    if (div_done) begin
                        t0_reg    <= div_quot;
                        state_reg <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        enter_reg <= enter_new;
                        exit_reg  <= exit_new;
                        state_reg <= ST_SLAB;
                    end
                end
                ST_SLAB: begin
                    if (enter_reg > exit_reg) begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_UPDATE;
                    end else if (axis_reg == 2'd2) begin
                        hit_reg   <= 1'b1;
                        state_reg <= ST_UPDATE;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_AXIS;
                    end
                end
                ST_UPDATE: begin
                    // Only a strictly closer box replaces the running best.
                    if (hit_reg && (enter_reg < T_W'(running_best))) begin
                        best_dist_reg   <= enter_reg[DIST_W-1:0];
                        best_owner_reg  <= item_reg.owner & OWN_MASK;
                        owner_valid_reg <= 1'b1;
                    end
                    state_reg <= item_reg.last_item ? ST_RESOLVE : ST_IDLE;
                end
                ST_RESOLVE: begin
                    // Terrain wins ties with the best box.
                    if (item_reg.terrain_hit && (item_reg.terrain_distance <= running_best)) begin
                        res_reg.victim_found <= 1'b0;
                        res_reg.victim       <= '0;
                        res_reg.terrain_won  <= 1'b1;
                        res_reg.hit_distance <= item_reg.terrain_distance;
                    end else begin
                        res_reg.victim_found <= owner_valid_reg;
                        res_reg.victim       <= owner_valid_reg ? best_owner_reg : 8'd0;
                        res_reg.terrain_won  <= 1'b0;
                        res_reg.hit_distance <= running_best;
                    end
                    imp_cnt_reg <= '0;
                    state_reg   <= ST_IMP;
                end
                ST_IMP: begin
                    imp_cnt_reg <= imp_cnt_reg + 3'd1;
                    if (imp_cnt_reg == 3'd4) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // The result waits here until the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg      <= res_reg;
                        m_valid_reg     <= 1'b1;
                        owner_valid_reg <= 1'b0;
                        best_owner_reg  <= '0;
                        best_dist_reg   <= max_dist_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule
